### design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the design files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/vmpc_pkg.sv
// ---------------------------------------------------------------------------
// VMPC keystream package
// Item types, command codes, sequencer states and sizing constants.
// ---------------------------------------------------------------------------
package vmpc_pkg;

  localparam int KEY_BYTES_DEF   = 64;
  localparam int SCHED_ROUNDS_DEF = 768;
  localparam int KEY_DEPTH       = 64;
  localparam int KEY_AW          = $clog2(KEY_DEPTH);
  localparam int PERM_DEPTH      = 256;
  localparam int MAX_REDRAWS     = 4096;
  localparam int REDRAW_W        = $clog2(MAX_REDRAWS + 1);

  typedef enum logic [2:0] {
    CMD_LOAD_KEY = 3'd0,
    CMD_LOAD_IV  = 3'd1,
    CMD_SCHEDULE = 3'd2,
    CMD_GENERATE = 3'd3,
    CMD_DRAW     = 3'd4
  } vmpc_cmd_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [5:0]  byte_index;
    logic [7:0]  byte_value;
    logic [3:0]  byte_count;
    logic        wide_draw;
    logic [63:0] draw_range;
  } vmpc_in_t;

  typedef struct packed {
    logic [63:0] random_value;
    logic [3:0]  valid_bytes;
  } vmpc_out_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FILL,
    ST_MIX_RI,
    ST_MIX_RX,
    ST_MIX_RJ,
    ST_MIX_WI,
    ST_MIX_WJ,
    ST_GEN_RI,
    ST_GEN_RX,
    ST_GEN_RJ,
    ST_GEN_RB,
    ST_GEN_RC,
    ST_GEN_WI,
    ST_GEN_WJ,
    ST_RNG_CHK,
    ST_RNG_LIM,
    ST_RNG_MOD
  } vmpc_state_t;

endpackage

### design/vmpc_keystream_generator.sv
// ---------------------------------------------------------------------------
// VMPC keystream generator
// Byte generator over a 256-entry permutation with key schedule and
// rejection-sampled ranged draws.
// ---------------------------------------------------------------------------
// Channel   Ports                       Handshake
// input     start, busy, in_item        taken when start is high, busy low
// result    out_valid, out_item         one-cycle strobe, no back-pressure
//
// Key and IV loads leave busy low.
// A schedule writes all 256 table entries, then runs 2 * SCHEDULE_ROUNDS
// rounds of reads and swaps through the single permutation memory port.
// Each keystream byte is built from dependent table reads and swap writes.
// A ranged draw adds a remainder pass for the limit and one for the
// result, plus one word per redraw. The table reads as all zero after reset
// until the first schedule fills it.
`include "assert_macros.svh"

module vmpc_keystream_generator
  import vmpc_pkg::*;
#(
  parameter int KEY_BYTES       = KEY_BYTES_DEF,
  parameter int SCHEDULE_ROUNDS = SCHED_ROUNDS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  vmpc_in_t  in_item,
  output logic      out_valid,
  output vmpc_out_t out_item
);

  localparam int LW = $clog2(SCHEDULE_ROUNDS);

  vmpc_state_t state_r, state_nxt;

  logic [7:0]  perm_mem [PERM_DEPTH];
  logic        perm_init_r;
  logic [7:0]  p_rdata_r;
  logic        p_rvld_r;
  logic [7:0]  p_raddr;
  logic        p_we;
  logic [7:0]  p_waddr;
  logic [7:0]  p_wdata;
  logic [7:0]  pq;

  logic [7:0]  key_mem [2*KEY_DEPTH];
  logic [2*KEY_DEPTH-1:0] key_vld_r;
  logic [7:0]  k_rdata_r;
  logic        k_rvld_r;
  logic [KEY_AW:0] k_raddr;
  logic        k_we;
  logic [KEY_AW:0] k_waddr;
  logic [7:0]  kq;

  logic [7:0]  i_r, i_nxt;
  logic [7:0]  j_r, j_nxt;
  logic [7:0]  a_r, a_nxt;
  logic [7:0]  b_r, b_nxt;
  logic [63:0] word_r, word_nxt;
  logic [3:0]  k_r, k_nxt;
  logic [3:0]  n_r, n_nxt;
  logic [LW-1:0] l_r, l_nxt;
  logic [KEY_AW-1:0] kidx_r, kidx_nxt;
  logic        iv_r, iv_nxt;
  logic        ranged_r, ranged_nxt;
  logic        wide_r, wide_nxt;
  logic [63:0] range_r, range_nxt;
  logic [63:0] lim_r, lim_nxt;
  logic        lim_ok_r, lim_ok_nxt;
  logic [REDRAW_W-1:0] redraw_r, redraw_nxt;
  logic        out_valid_r, out_valid_nxt;
  vmpc_out_t   out_r, out_nxt;

  logic        div_start;
  logic [63:0] div_dividend;
  logic        div_done;
  logic [63:0] div_rem;
  logic [63:0] neg_range;
  logic [63:0] neg_rem;
  logic [3:0]  cnt_sat;
  logic        accept;

  vmpc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (range_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign pq     = p_rvld_r ? p_rdata_r : 8'd0;
  assign kq     = k_rvld_r ? k_rdata_r : 8'd0;
  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);
  assign neg_range = 64'd0 - range_r;
  assign neg_rem   = 64'd0 - div_rem;
  assign cnt_sat   = (in_item.byte_count > 4'd8) ? 4'd8 : in_item.byte_count;

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    word_nxt      = word_r;
    k_nxt         = k_r;
    n_nxt         = n_r;
    l_nxt         = l_r;
    kidx_nxt      = kidx_r;
    iv_nxt        = iv_r;
    ranged_nxt    = ranged_r;
    wide_nxt      = wide_r;
    range_nxt     = range_r;
    lim_nxt       = lim_r;
    lim_ok_nxt    = lim_ok_r;
    redraw_nxt    = redraw_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    p_raddr       = i_r;
    p_we          = 1'b0;
    p_waddr       = i_r;
    p_wdata       = b_r;
    k_raddr       = {iv_r, kidx_r};
    k_we          = 1'b0;
    k_waddr       = {(in_item.cmd == CMD_LOAD_IV), in_item.byte_index};
    div_start     = 1'b0;
    div_dividend  = word_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_item.cmd)
            CMD_LOAD_KEY, CMD_LOAD_IV: begin
              k_we = ({1'b0, in_item.byte_index} < 7'(KEY_BYTES));
            end
            CMD_SCHEDULE: begin
              l_nxt     = '0;
              kidx_nxt  = '0;
              iv_nxt    = 1'b0;
              state_nxt = ST_FILL;
            end
            CMD_GENERATE: begin
              if (in_item.byte_count != 4'd0) begin
                word_nxt   = '0;
                k_nxt      = '0;
                n_nxt      = cnt_sat;
                ranged_nxt = 1'b0;
                state_nxt  = ST_GEN_RI;
              end
            end
            CMD_DRAW: begin
              word_nxt   = '0;
              k_nxt      = '0;
              n_nxt      = in_item.wide_draw ? 4'd8 : 4'd4;
              ranged_nxt = 1'b1;
              wide_nxt   = in_item.wide_draw;
              range_nxt  = in_item.wide_draw ? in_item.draw_range
                                             : {32'd0, in_item.draw_range[31:0]};
              lim_ok_nxt = 1'b0;
              redraw_nxt = '0;
              state_nxt  = ST_GEN_RI;
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        p_we    = 1'b1;
        p_waddr = l_r[7:0];
        p_wdata = l_r[7:0];
        if (l_r[7:0] == 8'hFF) begin
          l_nxt     = '0;
          state_nxt = ST_MIX_RI;
        end else begin
          l_nxt = l_r + LW'(1);
        end
      end
      ST_MIX_RI: begin
        p_raddr   = l_r[7:0];
        state_nxt = ST_MIX_RX;
      end
      ST_MIX_RX: begin
        a_nxt     = pq;
        p_raddr   = j_r + pq + kq;
        state_nxt = ST_MIX_RJ;
      end
      ST_MIX_RJ: begin
        j_nxt     = pq;
        p_raddr   = pq;
        state_nxt = ST_MIX_WI;
      end
      ST_MIX_WI: begin
        p_we      = 1'b1;
        p_waddr   = l_r[7:0];
        p_wdata   = pq;
        state_nxt = ST_MIX_WJ;
      end
      ST_MIX_WJ: begin
        p_we     = 1'b1;
        p_waddr  = j_r;
        p_wdata  = a_r;
        kidx_nxt = (kidx_r == KEY_AW'(KEY_BYTES - 1)) ? '0 : kidx_r + KEY_AW'(1);
        l_nxt    = l_r + LW'(1);
        state_nxt = ST_MIX_RI;
        if (l_r == LW'(SCHEDULE_ROUNDS - 1)) begin
          l_nxt    = '0;
          kidx_nxt = '0;
          if (iv_r) begin
            i_nxt     = 8'd0;
            state_nxt = ST_IDLE;
          end else begin
            iv_nxt = 1'b1;
          end
        end
      end
      ST_GEN_RI: begin
        p_raddr   = i_r;
        state_nxt = ST_GEN_RX;
      end
      ST_GEN_RX: begin
        a_nxt     = pq;
        p_raddr   = j_r + pq;
        state_nxt = ST_GEN_RJ;
      end
      ST_GEN_RJ: begin
        j_nxt     = pq;
        p_raddr   = pq;
        state_nxt = ST_GEN_RB;
      end
      ST_GEN_RB: begin
        b_nxt     = pq;
        p_raddr   = pq;
        state_nxt = ST_GEN_RC;
      end
      ST_GEN_RC: begin
        p_raddr   = pq + 8'd1;
        state_nxt = ST_GEN_WI;
      end
      ST_GEN_WI: begin
        word_nxt[{k_r[2:0], 3'b000} +: 8] = pq;
        p_we      = 1'b1;
        p_waddr   = i_r;
        p_wdata   = b_r;
        state_nxt = ST_GEN_WJ;
      end
      ST_GEN_WJ: begin
        p_we      = 1'b1;
        p_waddr   = j_r;
        p_wdata   = a_r;
        i_nxt     = i_r + 8'd1;
        k_nxt     = k_r + 4'd1;
        state_nxt = ST_GEN_RI;
        if (k_r + 4'd1 == n_r) begin
          if (ranged_r) begin
            state_nxt = ST_RNG_CHK;
          end else begin
            out_valid_nxt        = 1'b1;
            out_nxt.random_value = word_r;
            out_nxt.valid_bytes  = n_r;
            state_nxt            = ST_IDLE;
          end
        end
      end
      ST_RNG_CHK: begin
        if (range_r == 64'd0) begin
          out_valid_nxt        = 1'b1;
          out_nxt.random_value = word_r;
          out_nxt.valid_bytes  = n_r;
          state_nxt            = ST_IDLE;
        end else if (!lim_ok_r) begin
          div_start    = 1'b1;
          div_dividend = wide_r ? neg_range : {32'd0, neg_range[31:0]};
          state_nxt    = ST_RNG_LIM;
        end else if (lim_r != 64'd0 && word_r >= lim_r &&
                     redraw_r != REDRAW_W'(MAX_REDRAWS)) begin
          redraw_nxt = redraw_r + REDRAW_W'(1);
          word_nxt   = '0;
          k_nxt      = '0;
          state_nxt  = ST_GEN_RI;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_RNG_MOD;
        end
      end
      ST_RNG_LIM: begin
        if (div_done) begin
          lim_nxt    = wide_r ? neg_rem : {32'd0, neg_rem[31:0]};
          lim_ok_nxt = 1'b1;
          state_nxt  = ST_RNG_CHK;
        end
      end
      ST_RNG_MOD: begin
        if (div_done) begin
          out_valid_nxt        = 1'b1;
          out_nxt.random_value = div_rem;
          out_nxt.valid_bytes  = n_r;
          state_nxt            = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
      perm_init_r <= 1'b0;
      key_vld_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == ST_FILL) begin
        perm_init_r <= 1'b1;
      end
      if (k_we) begin
        key_vld_r[k_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    word_r   <= word_nxt;
    k_r      <= k_nxt;
    n_r      <= n_nxt;
    l_r      <= l_nxt;
    kidx_r   <= kidx_nxt;
    iv_r     <= iv_nxt;
    ranged_r <= ranged_nxt;
    wide_r   <= wide_nxt;
    range_r  <= range_nxt;
    lim_r    <= lim_nxt;
    lim_ok_r <= lim_ok_nxt;
    redraw_r <= redraw_nxt;
    out_r    <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      perm_mem[p_waddr] <= p_wdata;
    end
    p_rdata_r <= perm_mem[p_raddr];
    p_rvld_r  <= perm_init_r;
  end

  always_ff @(posedge clk) begin
    if (k_we) begin
      key_mem[k_waddr] <= in_item.byte_value;
    end
    k_rdata_r <= key_mem[k_raddr];
    k_rvld_r  <= key_vld_r[k_raddr];
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `ASSERT_SAME(a_out_when_idle, out_valid_r, !busy)
  `ASSERT_NEXT(a_zero_count_no_work,
    accept && in_item.cmd == CMD_GENERATE && in_item.byte_count == 4'd0,
    !busy && !out_valid_r)
  `ASSERT_SAME(a_div_done_in_wait, div_done,
    state_r == ST_RNG_LIM || state_r == ST_RNG_MOD)

endmodule

### design/vmpc_div.sv
// ---------------------------------------------------------------------------
// VMPC remainder unit
// Restoring 64-bit divider that produces one quotient bit per cycle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module vmpc_div
  import vmpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] rem
);

  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [63:0] dvs_r, dvs_nxt;
  logic [64:0] shifted;
  logic [64:0] diff;

  always_comb begin
    shifted  = {rem_r, quo_r[63]};
    diff     = shifted - {1'b0, dvs_r};
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
    end else if (run_r) begin
      rem_nxt = diff[64] ? shifted[63:0] : diff[63:0];
      quo_nxt = {quo_r[62:0], 1'b0};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

  `ASSERT_NEXT(a_div_start_runs, start, run_r && !done_r)
  `ASSERT_SAME(a_div_done_idle, done_r, !run_r)

endmodule
